[sv/tbaf_pkg.sv]
// ----------------------------------------------------------------------------
// Triclinic box atom filter package
// Widths, build constants and register indexes shared by the filter files.
// ----------------------------------------------------------------------------
package tbaf_pkg;

    // 2 or 3; in a 2-D build the z axis is neither transformed nor tested
    localparam int DIMENSIONS = 3;
    // saturation point of the per-batch kept count
    localparam int MAX_BATCH  = 1048576;

    localparam int POS_W      = 32;                    // Q16.16 position
    localparam int COEF_W     = 32;                    // Q8.24 inverse-cell entry
    localparam int DIFF_W     = POS_W + 1;             // position minus origin
    localparam int PROD_W     = DIFF_W + COEF_W;       // exact Q.40 product
    localparam int SUM_W      = PROD_W + 2;            // sum of three products
    localparam int FRAC_SHIFT = 25;                    // Q.40 down to Q.15
    localparam int FRAC_W     = SUM_W - FRAC_SHIFT;    // floored Q.15 coordinate
    localparam int BOUND_W    = 16;                    // unsigned Q1.15 bound
    localparam int KIND_W     = 16;
    localparam int BASE_W     = 20;
    localparam int SLOT_W     = 21;
    localparam int CNT_W      = $clog2(MAX_BATCH + 1);

    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_DIAG_XY = 3'd0,
        REG_INV_ZZ_YZ   = 3'd1,
        REG_INV_XZ_XY   = 3'd2,
        REG_ORIGIN_XY   = 3'd3,
        REG_ORIGIN_Z    = 3'd4,
        REG_LOWER       = 3'd5,
        REG_UPPER       = 3'd6,
        REG_BASE_SLOT   = 3'd7
    } cfg_reg_t;

endpackage

[sv/tbaf_atom_if.sv]
// ----------------------------------------------------------------------------
// Atom request channel
// Valid/ready channel that carries one atom position, type and batch marker.
// ----------------------------------------------------------------------------
interface tbaf_atom_if;
    import tbaf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic        [KIND_W-1:0] atom_kind;
    logic                     batch_end;

    modport source (output valid, pos_x, pos_y, pos_z, atom_kind, batch_end,
                    input  ready);
    modport sink   (input  valid, pos_x, pos_y, pos_z, atom_kind, batch_end,
                    output ready);
endinterface

[sv/tbaf_result_if.sv]
// ----------------------------------------------------------------------------
// Filter result channel
// Valid/ready channel that carries the inside flag, slot and kept atom data.
// ----------------------------------------------------------------------------
interface tbaf_result_if;
    import tbaf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     is_inside;
    logic        [SLOT_W-1:0] dest_slot;
    logic        [KIND_W-1:0] kind_out;
    logic signed [POS_W-1:0]  out_x;
    logic signed [POS_W-1:0]  out_y;
    logic signed [POS_W-1:0]  out_z;
    logic                     batch_done;

    modport source (output valid, is_inside, dest_slot, kind_out, out_x, out_y,
                           out_z, batch_done,
                    input  ready);
    modport sink   (input  valid, is_inside, dest_slot, kind_out, out_x, out_y,
                           out_z, batch_done,
                    output ready);
endinterface

[sv/triclinic_box_atom_filter_unit.sv]
// ----------------------------------------------------------------------------
// Triclinic box atom filter
// Maps each atom into fractional cell coordinates, tests them against the
// configured bounds and assigns a destination slot to every kept atom.
// ----------------------------------------------------------------------------
// The unit takes one atom per clock while the pipe advances and returns one
// result per atom, in order: the first stage subtracts the box origin, the
// second forms the six 33x32 products of the upper-triangular inverse cell in
// parallel, and the third sums them exactly, floors to Q.15, runs the bound
// compares and loads the result register. All stages advance together while
// the result register is empty or being taken, so with a ready sink the rate
// is one atom per cycle. Outside atoms report zero slot, type and position.
// The kept count clears after an atom flagged as batch end; write the
// configuration registers only while no atom is in flight.
module triclinic_box_atom_filter_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [tbaf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tbaf_pkg::CFG_DATA_W-1:0]    cfg_data,
    tbaf_atom_if.sink                          atom_in,
    tbaf_result_if.source                      result_out
);
    import tbaf_pkg::*;

    localparam bit THREE_D = (DIMENSIONS == 3);

    // configuration
    logic [63:0]           inv_diag_xy_reg;
    logic [63:0]           inv_zz_yz_reg;
    logic [63:0]           inv_xz_xy_reg;
    logic [63:0]           origin_xy_reg;
    logic [POS_W-1:0]      origin_z_reg;
    logic [3*BOUND_W-1:0]  lower_reg;
    logic [3*BOUND_W-1:0]  upper_reg;
    logic [BASE_W-1:0]     base_slot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_diag_xy_reg <= '0;
            inv_zz_yz_reg   <= '0;
            inv_xz_xy_reg   <= '0;
            origin_xy_reg   <= '0;
            origin_z_reg    <= '0;
            lower_reg       <= '0;
            upper_reg       <= '0;
            base_slot_reg   <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INV_DIAG_XY: inv_diag_xy_reg <= cfg_data;
                REG_INV_ZZ_YZ:   inv_zz_yz_reg   <= cfg_data;
                REG_INV_XZ_XY:   inv_xz_xy_reg   <= cfg_data;
                REG_ORIGIN_XY:   origin_xy_reg   <= cfg_data;
                REG_ORIGIN_Z:    origin_z_reg    <= cfg_data[POS_W-1:0];
                REG_LOWER:       lower_reg       <= cfg_data[3*BOUND_W-1:0];
                REG_UPPER:       upper_reg       <= cfg_data[3*BOUND_W-1:0];
                REG_BASE_SLOT:   base_slot_reg   <= cfg_data[BASE_W-1:0];
                default:         ;
            endcase
        end
    end

    logic signed [COEF_W-1:0] c_xx, c_yy, c_zz, c_yz, c_xz, c_xy;
    logic signed [POS_W-1:0]  org_x, org_y, org_z;

    assign c_xx  = $signed(inv_diag_xy_reg[31:0]);
    assign c_yy  = $signed(inv_diag_xy_reg[63:32]);
    assign c_zz  = $signed(inv_zz_yz_reg[31:0]);
    assign c_yz  = $signed(inv_zz_yz_reg[63:32]);
    assign c_xz  = $signed(inv_xz_xy_reg[31:0]);
    assign c_xy  = $signed(inv_xz_xy_reg[63:32]);
    assign org_x = $signed(origin_xy_reg[31:0]);
    assign org_y = $signed(origin_xy_reg[63:32]);
    assign org_z = $signed(origin_z_reg);

    // the whole pipe moves when the result register is free or being taken
    logic adv;
    logic res_valid_reg;

    assign adv           = !res_valid_reg || result_out.ready;
    assign atom_in.ready = adv;

    // stage 1: offset from box origin
    logic                     s1_valid_reg;
    logic signed [DIFF_W-1:0] s1_dx_reg, s1_dy_reg, s1_dz_reg;
    logic signed [DIFF_W-1:0] s1_dx_next, s1_dy_next, s1_dz_next;
    logic signed [POS_W-1:0]  s1_x_reg, s1_y_reg, s1_z_reg;
    logic        [KIND_W-1:0] s1_kind_reg;
    logic                     s1_end_reg;

    always_comb
    begin
        s1_dx_next = DIFF_W'(atom_in.pos_x) - DIFF_W'(org_x);
        s1_dy_next = DIFF_W'(atom_in.pos_y) - DIFF_W'(org_y);
        s1_dz_next = THREE_D ? DIFF_W'(atom_in.pos_z) - DIFF_W'(org_z) : '0;
    end

    // stage 2: exact products
    logic                     s2_valid_reg;
    logic signed [PROD_W-1:0] p_xx_reg, p_xy_reg, p_xz_reg;
    logic signed [PROD_W-1:0] p_yy_reg, p_yz_reg, p_zz_reg;
    logic signed [POS_W-1:0]  s2_x_reg, s2_y_reg, s2_z_reg;
    logic        [KIND_W-1:0] s2_kind_reg;
    logic                     s2_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= atom_in.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_dx_reg   <= s1_dx_next;
            s1_dy_reg   <= s1_dy_next;
            s1_dz_reg   <= s1_dz_next;
            s1_x_reg    <= atom_in.pos_x;
            s1_y_reg    <= atom_in.pos_y;
            s1_z_reg    <= atom_in.pos_z;
            s1_kind_reg <= atom_in.atom_kind;
            s1_end_reg  <= atom_in.batch_end;

            p_xx_reg    <= PROD_W'(s1_dx_reg) * PROD_W'(c_xx);
            p_xy_reg    <= PROD_W'(s1_dy_reg) * PROD_W'(c_xy);
            p_xz_reg    <= PROD_W'(s1_dz_reg) * PROD_W'(c_xz);
            p_yy_reg    <= PROD_W'(s1_dy_reg) * PROD_W'(c_yy);
            p_yz_reg    <= PROD_W'(s1_dz_reg) * PROD_W'(c_yz);
            p_zz_reg    <= PROD_W'(s1_dz_reg) * PROD_W'(c_zz);
            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_z_reg    <= s1_z_reg;
            s2_kind_reg <= s1_kind_reg;
            s2_end_reg  <= s1_end_reg;
        end
    end

    // stage 3: sum, floor to Q.15 and bound test
    logic signed [SUM_W-1:0]  lam_x, lam_y, lam_z;
    logic signed [FRAC_W-1:0] q_x, q_y, q_z;
    logic                     in_x, in_y, in_z, in_box;

    function automatic logic bound_ok(input logic signed [FRAC_W-1:0] q,
                                      input logic [BOUND_W-1:0] lb,
                                      input logic [BOUND_W-1:0] ub);
        logic signed [FRAC_W-1:0] lb_s;
        logic signed [FRAC_W-1:0] ub_s;
        lb_s = $signed(FRAC_W'(lb));
        ub_s = $signed(FRAC_W'(ub));
        return (q >= lb_s) && (q < ub_s);
    endfunction

    always_comb
    begin
        lam_x  = SUM_W'(p_xx_reg) + SUM_W'(p_xy_reg) + SUM_W'(p_xz_reg);
        lam_y  = SUM_W'(p_yy_reg) + SUM_W'(p_yz_reg);
        lam_z  = SUM_W'(p_zz_reg);
        q_x    = $signed(lam_x[SUM_W-1:FRAC_SHIFT]);
        q_y    = $signed(lam_y[SUM_W-1:FRAC_SHIFT]);
        q_z    = $signed(lam_z[SUM_W-1:FRAC_SHIFT]);
        in_x   = bound_ok(q_x, lower_reg[BOUND_W-1:0], upper_reg[BOUND_W-1:0]);
        in_y   = bound_ok(q_y, lower_reg[2*BOUND_W-1:BOUND_W],
                          upper_reg[2*BOUND_W-1:BOUND_W]);
        in_z   = THREE_D ? bound_ok(q_z, lower_reg[3*BOUND_W-1:2*BOUND_W],
                                    upper_reg[3*BOUND_W-1:2*BOUND_W]) : 1'b1;
        in_box = in_x && in_y && in_z;
    end

    // kept count and result register
    logic [CNT_W-1:0]  kept_count_reg;
    logic [CNT_W-1:0]  kept_count_next;
    logic              load_res;
    logic [SLOT_W-1:0] slot_next;

    assign load_res  = adv && s2_valid_reg;
    assign slot_next = SLOT_W'(base_slot_reg) + SLOT_W'(kept_count_reg);

    always_comb
    begin
        kept_count_next = kept_count_reg;
        if (in_box && (kept_count_reg < CNT_W'(MAX_BATCH)))
        begin
            kept_count_next = kept_count_reg + CNT_W'(1);
        end
        if (s2_end_reg)
        begin
            kept_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            kept_count_reg <= '0;
        end
        else
        begin
            if (adv)
            begin
                res_valid_reg <= s2_valid_reg;
            end
            if (load_res)
            begin
                kept_count_reg <= kept_count_next;
            end
        end
    end

    logic                     res_inside_reg;
    logic        [SLOT_W-1:0] res_slot_reg;
    logic        [KIND_W-1:0] res_kind_reg;
    logic signed [POS_W-1:0]  res_x_reg, res_y_reg, res_z_reg;
    logic                     res_end_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_inside_reg <= in_box;
            res_slot_reg   <= in_box ? slot_next : '0;
            res_kind_reg   <= in_box ? s2_kind_reg : '0;
            res_x_reg      <= in_box ? s2_x_reg : '0;
            res_y_reg      <= in_box ? s2_y_reg : '0;
            res_z_reg      <= (in_box && THREE_D) ? s2_z_reg : '0;
            res_end_reg    <= s2_end_reg;
        end
    end

    assign result_out.valid      = res_valid_reg;
    assign result_out.is_inside  = res_inside_reg;
    assign result_out.dest_slot  = res_slot_reg;
    assign result_out.kind_out   = res_kind_reg;
    assign result_out.out_x      = res_x_reg;
    assign result_out.out_y      = res_y_reg;
    assign result_out.out_z      = res_z_reg;
    assign result_out.batch_done = res_end_reg;

    // assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_count_reg <= CNT_W'(MAX_BATCH))
        else $error("kept count above saturation point");

    a_batch_clear: assert property (@(posedge clk) disable iff (!rst_n)
        load_res && s2_end_reg |=> kept_count_reg == '0)
        else $error("kept count not cleared after batch end");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_inside_reg |->
            res_slot_reg == '0 && res_kind_reg == '0 && res_x_reg == '0)
        else $error("outside atom carries data");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        load_res && !s2_end_reg && in_box && kept_count_reg < CNT_W'(MAX_BATCH)
            |=> kept_count_reg == $past(kept_count_reg) + CNT_W'(1))
        else $error("kept count did not advance for kept atom");

endmodule
